[rtl/ipt_lru_pkg.sv]
// Shared types and constants for the inverted page table with LRU replacement.
`default_nettype none

package ipt_lru_pkg;

   // Default number of physical frames tracked by the table.
   localparam int FRAME_COUNT_DEF = 64;

   // Fixed field widths of the request and response beats.
   localparam int FRAME_W = 6;
   localparam int PID_W   = 16;
   localparam int PAGE_W  = 20;
   localparam int STAMP_W = 32;

   // Operation codes carried by req_opcode.
   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_TOUCH = 2'd1,
      OP_DIRTY = 2'd2,
      OP_EVICT = 2'd3
   } ipt_op_type;

   // One table entry as held in the entry memory.
   typedef struct packed {
      logic               valid;
      logic               dirty;
      logic [STAMP_W-1:0] stamp;
      logic [PAGE_W-1:0]  page;
      logic [PID_W-1:0]   pid;
   } ipt_entry_type;

   // Control from the sequencer to the shared minimum unit.
   typedef struct packed {
      logic clear;
      logic sample;
   } ipt_scan_ctl_type;

endpackage

`default_nettype wire

[rtl/ipt_lru_entry_ram.sv]
// Entry memory: one write port and one registered read port.
`default_nettype none

module ipt_lru_entry_ram #(
   parameter int DEPTH = ipt_lru_pkg::FRAME_COUNT_DEF,
   parameter int AW    = $clog2(ipt_lru_pkg::FRAME_COUNT_DEF)
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire ipt_lru_pkg::ipt_entry_type wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output      ipt_lru_pkg::ipt_entry_type rd_data
);

   ipt_lru_pkg::ipt_entry_type mem [DEPTH];
   ipt_lru_pkg::ipt_entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/ipt_lru_min_unit.sv]
// Shared comparator that tracks the oldest valid entry seen during a scan.
`default_nettype none

module ipt_lru_min_unit #(
   parameter int AW = $clog2(ipt_lru_pkg::FRAME_COUNT_DEF)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ipt_lru_pkg::ipt_scan_ctl_type ctl,
   input  wire logic [AW-1:0]                 sample_idx,
   input  wire ipt_lru_pkg::ipt_entry_type    sample_entry,
   output      logic                          found,
   output      logic [AW-1:0]                 best_idx,
   output      ipt_lru_pkg::ipt_entry_type    best_entry
);

   logic                       found_ff;
   logic                       found_in;
   logic [AW-1:0]              best_idx_ff;
   ipt_lru_pkg::ipt_entry_type best_ff;
   logic                       take;

   // Strictly older stamps win, so ties keep the lower frame seen first.
   assign take = ctl.sample && sample_entry.valid &&
                 (!found_ff || (sample_entry.stamp < best_ff.stamp));

   always_comb begin
      found_in = found_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
      end
   end

   // Found flag is control state; the captured entry is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && !ctl.clear) begin
         best_ff     <= sample_entry;
         best_idx_ff <= sample_idx;
      end
   end

   assign found      = found_ff;
   assign best_idx   = best_idx_ff;
   assign best_entry = best_ff;

`ifndef SYNTH
   // Once a candidate is held, only a new scan can drop it.
   a_found_sticky: assert property (@(posedge clock) disable iff (reset)
      (found_ff && !ctl.clear) |=> found_ff)
      else $error("minimum unit lost its candidate mid scan");
`endif

endmodule

`default_nettype wire

[rtl/inverted_page_table_lru_top.sv]
// Top level: inverted page table with least-recently-used eviction.
//
// A request beat is taken at a rising edge with start high and busy low.
// req_opcode selects allocate, touch, mark dirty or evict; frames at or
// beyond FRAME_COUNT are ignored, as are touch and mark dirty of an invalid
// frame. Only evict gives a response beat: rsp_strobe is high for exactly
// one cycle with the victim's frame, process, page and dirty mark, or with
// rsp_table_empty set and the other fields zero. The receiver cannot stall,
// so the response is never held.
// Allocate writes the entry directly; touch and mark dirty read the entry,
// then write it back. Evict keeps busy high while it scans every frame,
// and its response appears in the same cycle that busy falls. The scan
// reads one entry a cycle from the single read port of the entry memory
// and feeds it to one shared 32-bit comparator. A new request may be
// taken while a response shows. After reset a clearing pass writes every
// entry invalid, keeping busy high until it is done, so no request is
// taken before it ends.
`default_nettype none

module inverted_page_table_lru_top #(
   parameter int FRAME_COUNT = ipt_lru_pkg::FRAME_COUNT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output      logic                               busy,
   input  wire logic [1:0]                         req_opcode,
   input  wire logic [ipt_lru_pkg::FRAME_W-1:0]    req_frame_index,
   input  wire logic [ipt_lru_pkg::PID_W-1:0]      req_owner_pid,
   input  wire logic [ipt_lru_pkg::PAGE_W-1:0]     req_virtual_page,
   input  wire logic [ipt_lru_pkg::STAMP_W-1:0]    req_ref_time,
   input  wire logic                               req_dirty_in,
   output      logic                               rsp_strobe,
   output      logic [ipt_lru_pkg::FRAME_W-1:0]    rsp_victim_frame,
   output      logic [ipt_lru_pkg::PID_W-1:0]      rsp_victim_pid,
   output      logic [ipt_lru_pkg::PAGE_W-1:0]     rsp_victim_page,
   output      logic                               rsp_victim_dirty,
   output      logic                               rsp_table_empty
);

   localparam int AW = $clog2(FRAME_COUNT);
   localparam int CW = AW + 1;
   localparam int IW = (AW > ipt_lru_pkg::FRAME_W) ? AW : ipt_lru_pkg::FRAME_W;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_CLEAR    = 7'b0000010,
      ST_ALLOC    = 7'b0000100,
      ST_RMW_RD   = 7'b0001000,
      ST_RMW_WR   = 7'b0010000,
      ST_SCAN     = 7'b0100000,
      ST_EV_DONE  = 7'b1000000
   } state_type;

   state_type                         state_ff, state_in;
   logic [CW-1:0]                     cnt_ff, cnt_in;
   logic                              rd_valid_ff, rd_valid_in;
   logic [AW-1:0]                     rd_idx_ff, rd_idx_in;
   ipt_lru_pkg::ipt_op_type           op_ff;
   logic [AW-1:0]                     addr_ff;
   logic [ipt_lru_pkg::PID_W-1:0]     pid_ff;
   logic [ipt_lru_pkg::PAGE_W-1:0]    page_ff;
   logic [ipt_lru_pkg::STAMP_W-1:0]   time_ff;
   logic                              dirty_ff;

   logic                              rsp_strobe_ff, rsp_strobe_in;
   logic [ipt_lru_pkg::FRAME_W-1:0]   rsp_frame_ff;
   logic [ipt_lru_pkg::PID_W-1:0]     rsp_pid_ff;
   logic [ipt_lru_pkg::PAGE_W-1:0]    rsp_page_ff;
   logic                              rsp_dirty_ff;
   logic                              rsp_empty_ff;

   logic                              accept;
   logic [IW:0]                       frame_wide;
   logic                              addressable;
   ipt_lru_pkg::ipt_op_type           req_op;
   logic                              scan_more;

   logic                              wr_en;
   logic [AW-1:0]                     wr_addr;
   ipt_lru_pkg::ipt_entry_type        wr_data;
   logic                              rd_en;
   logic [AW-1:0]                     rd_addr;
   ipt_lru_pkg::ipt_entry_type        rd_data;

   ipt_lru_pkg::ipt_scan_ctl_type     scan_ctl;
   logic                              best_found;
   logic [AW-1:0]                     best_idx;
   ipt_lru_pkg::ipt_entry_type        best_entry;
   logic [IW:0]                       best_wide;

   // Request decode.
   assign accept      = start && !busy;
   assign req_op      = ipt_lru_pkg::ipt_op_type'(req_opcode);
   assign frame_wide  = (IW+1)'(req_frame_index);
   assign addressable = frame_wide < (IW+1)'(FRAME_COUNT);
   assign scan_more   = cnt_ff < CW'(FRAME_COUNT);
   assign busy        = (state_ff != ST_IDLE);

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      rd_valid_in = 1'b0;
      rd_idx_in   = cnt_ff[AW-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(FRAME_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               unique case (req_op)
                  ipt_lru_pkg::OP_ALLOC: begin
                     state_in = addressable ? ST_ALLOC : ST_IDLE;
                  end
                  ipt_lru_pkg::OP_TOUCH, ipt_lru_pkg::OP_DIRTY: begin
                     state_in = addressable ? ST_RMW_RD : ST_IDLE;
                  end
                  ipt_lru_pkg::OP_EVICT: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ALLOC: begin
            state_in = ST_IDLE;
         end
         ST_RMW_RD: begin
            state_in = ST_RMW_WR;
         end
         ST_RMW_WR: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            rd_valid_in = scan_more;
            if (scan_more) begin
               cnt_in = cnt_ff + CW'(1);
            end else if (!rd_valid_ff) begin
               state_in = ST_EV_DONE;
            end
         end
         ST_EV_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         cnt_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // Request capture and scan index pipeline.
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      if (accept) begin
         op_ff    <= req_op;
         addr_ff  <= frame_wide[AW-1:0];
         pid_ff   <= req_owner_pid;
         page_ff  <= req_virtual_page;
         time_ff  <= req_ref_time;
         dirty_ff <= req_dirty_in;
      end
   end

   // Memory port steering.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = rd_data;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[AW-1:0];
            wr_data = '0;
         end
         ST_ALLOC: begin
            wr_en         = 1'b1;
            wr_data.valid = 1'b1;
            wr_data.dirty = dirty_ff;
            wr_data.stamp = time_ff;
            wr_data.page  = page_ff;
            wr_data.pid   = pid_ff;
         end
         ST_RMW_WR: begin
            wr_en = rd_data.valid;
            if (op_ff == ipt_lru_pkg::OP_TOUCH) begin
               wr_data.stamp = time_ff;
            end else begin
               wr_data.dirty = 1'b1;
            end
         end
         ST_EV_DONE: begin
            wr_en         = best_found;
            wr_addr       = best_idx;
            wr_data       = best_entry;
            wr_data.valid = 1'b0;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign rd_en   = (state_ff == ST_RMW_RD) || ((state_ff == ST_SCAN) && scan_more);
   assign rd_addr = (state_ff == ST_SCAN) ? cnt_ff[AW-1:0] : addr_ff;

   ipt_lru_entry_ram #(
      .DEPTH (FRAME_COUNT),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Scan control for the shared comparator.
   assign scan_ctl.clear  = accept;
   assign scan_ctl.sample = rd_valid_ff;

   ipt_lru_min_unit #(
      .AW (AW)
   ) u_min (
      .clock        (clock),
      .reset        (reset),
      .ctl          (scan_ctl),
      .sample_idx   (rd_idx_ff),
      .sample_entry (rd_data),
      .found        (best_found),
      .best_idx     (best_idx),
      .best_entry   (best_entry)
   );

   // Response beat register.
   assign rsp_strobe_in = (state_ff == ST_EV_DONE);
   assign best_wide     = (IW+1)'(best_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_strobe_in) begin
         rsp_empty_ff <= !best_found;
         if (best_found) begin
            rsp_frame_ff <= best_wide[ipt_lru_pkg::FRAME_W-1:0];
            rsp_pid_ff   <= best_entry.pid;
            rsp_page_ff  <= best_entry.page;
            rsp_dirty_ff <= best_entry.dirty;
         end else begin
            rsp_frame_ff <= '0;
            rsp_pid_ff   <= '0;
            rsp_page_ff  <= '0;
            rsp_dirty_ff <= 1'b0;
         end
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_victim_frame = rsp_frame_ff;
   assign rsp_victim_pid   = rsp_pid_ff;
   assign rsp_victim_page  = rsp_page_ff;
   assign rsp_victim_dirty = rsp_dirty_ff;
   assign rsp_table_empty  = rsp_empty_ff;

`ifndef SYNTH
   // A response beat only follows the final step of an evict.
   a_rsp_after_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_EV_DONE))
      else $error("response beat without a finished evict");

   // An empty-table response carries zero victim fields.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_empty_ff) |->
         (rsp_frame_ff == '0 && rsp_pid_ff == '0 && rsp_page_ff == '0 && !rsp_dirty_ff))
      else $error("empty-table response with nonzero fields");

   // The table is never written while a scan is in flight.
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !wr_en)
      else $error("entry write during evict scan");

   // The clearing pass holds off requests right after reset.
   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) |-> busy)
      else $error("request port open before the clearing pass");
`endif

endmodule

`default_nettype wire

[tb/sv/inverted_page_table_lru_top_tb.sv]
// Self-checking testbench for the inverted page table with LRU eviction.
`default_nettype none

module inverted_page_table_lru_top_tb;
   import ipt_lru_pkg::*;

   localparam int FRAMES      = FRAME_COUNT_DEF;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_BEATS = 600;

   // One eviction outcome as the block reports it.
   typedef struct {
      logic [FRAME_W-1:0] frame;
      logic [PID_W-1:0]   pid;
      logic [PAGE_W-1:0]  page;
      logic               dirty;
      logic               empty;
   } victim_rec;

   // Shadow copy of the frame table and the evictions it still owes.
   class frame_table_tracker;
      bit                 valid [FRAMES];
      bit [PID_W-1:0]     pid [FRAMES];
      bit [PAGE_W-1:0]    page [FRAMES];
      bit [STAMP_W-1:0]   stamp [FRAMES];
      bit                 dirty [FRAMES];
      victim_rec          pending_victims[$];
      int                 error_count = 0;

      // Apply one accepted request beat to the shadow table.
      function void apply_request(ipt_op_type op, logic [FRAME_W-1:0] frame,
                                  logic [PID_W-1:0] req_pid,
                                  logic [PAGE_W-1:0] req_page,
                                  logic [STAMP_W-1:0] req_stamp, logic req_dirty);
         victim_rec v;
         bit        found;
         int        best;
         found = 1'b0;
         best  = 0;
         case (op)
            OP_ALLOC: begin
               if (frame < FRAMES) begin
                  valid[frame] = 1'b1;
                  pid[frame]   = req_pid;
                  page[frame]  = req_page;
                  stamp[frame] = req_stamp;
                  dirty[frame] = req_dirty;
               end
            end
            OP_TOUCH: begin
               if (frame < FRAMES && valid[frame]) stamp[frame] = req_stamp;
            end
            OP_DIRTY: begin
               if (frame < FRAMES && valid[frame]) dirty[frame] = 1'b1;
            end
            default: begin
               // Oldest valid stamp wins; the lowest frame wins a tie.
               for (int i = 0; i < FRAMES; i++) begin
                  if (valid[i] && (!found || stamp[i] < stamp[best])) begin
                     best  = i;
                     found = 1'b1;
                  end
               end
               if (found) begin
                  v.frame = best[FRAME_W-1:0];
                  v.pid   = pid[best];
                  v.page  = page[best];
                  v.dirty = dirty[best];
                  v.empty = 1'b0;
                  valid[best] = 1'b0;
               end else begin
                  v.frame = '0;
                  v.pid   = '0;
                  v.page  = '0;
                  v.dirty = 1'b0;
                  v.empty = 1'b1;
               end
               pending_victims.push_back(v);
            end
         endcase
      endfunction

      // Compare a response beat with the oldest owed eviction.
      function void check_victim(victim_rec got);
         victim_rec want;
         if (pending_victims.size() == 0) begin
            $display("%0t: unexpected response beat, frame %0d empty %0b",
                     $time, got.frame, got.empty);
            error_count++;
            return;
         end
         want = pending_victims.pop_front();
         if (got.frame !== want.frame) begin
            $display("%0t: victim_frame expected %0d got %0d", $time, want.frame, got.frame);
            error_count++;
         end
         if (got.pid !== want.pid) begin
            $display("%0t: victim_pid expected %h got %h", $time, want.pid, got.pid);
            error_count++;
         end
         if (got.page !== want.page) begin
            $display("%0t: victim_page expected %h got %h", $time, want.page, got.page);
            error_count++;
         end
         if (got.dirty !== want.dirty) begin
            $display("%0t: victim_dirty expected %0b got %0b", $time, want.dirty, got.dirty);
            error_count++;
         end
         if (got.empty !== want.empty) begin
            $display("%0t: table_empty expected %0b got %0b", $time, want.empty, got.empty);
            error_count++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_opcode;
   logic [FRAME_W-1:0] req_frame_index;
   logic [PID_W-1:0]   req_owner_pid;
   logic [PAGE_W-1:0]  req_virtual_page;
   logic [STAMP_W-1:0] req_ref_time;
   logic               req_dirty_in;
   logic               rsp_strobe;
   logic [FRAME_W-1:0] rsp_victim_frame;
   logic [PID_W-1:0]   rsp_victim_pid;
   logic [PAGE_W-1:0]  rsp_victim_page;
   logic               rsp_victim_dirty;
   logic               rsp_table_empty;
   int                 cycle_count = 0;

   frame_table_tracker tracker = new();

   inverted_page_table_lru_top #(.FRAME_COUNT(FRAMES)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_frame_index(req_frame_index),
      .req_owner_pid(req_owner_pid),
      .req_virtual_page(req_virtual_page),
      .req_ref_time(req_ref_time),
      .req_dirty_in(req_dirty_in),
      .rsp_strobe(rsp_strobe),
      .rsp_victim_frame(rsp_victim_frame),
      .rsp_victim_pid(rsp_victim_pid),
      .rsp_victim_page(rsp_victim_page),
      .rsp_victim_dirty(rsp_victim_dirty),
      .rsp_table_empty(rsp_table_empty)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Observe accepted request beats and response beats at each edge.
   always @(posedge clock) begin
      victim_rec got;
      if (!reset) begin
         if (rsp_strobe) begin
            got.frame = rsp_victim_frame;
            got.pid   = rsp_victim_pid;
            got.page  = rsp_victim_page;
            got.dirty = rsp_victim_dirty;
            got.empty = rsp_table_empty;
            tracker.check_victim(got);
         end
         if (start && !busy)
            tracker.apply_request(ipt_op_type'(req_opcode), req_frame_index, req_owner_pid,
                                  req_virtual_page, req_ref_time, req_dirty_in);
      end
   end

   // Present one request beat and hold it until the block takes it.
   task automatic issue(input ipt_op_type op, input logic [FRAME_W-1:0] frame,
                        input logic [PID_W-1:0] pid, input logic [PAGE_W-1:0] page,
                        input logic [STAMP_W-1:0] stamp, input logic dirty);
      req_opcode       <= op;
      req_frame_index  <= frame;
      req_owner_pid    <= pid;
      req_virtual_page <= page;
      req_ref_time     <= stamp;
      req_dirty_in     <= dirty;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Drop start for a number of cycles.
   task automatic idle(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Gap length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 11) return 0;
      if (sel < 17) return $urandom_range(1, 3);
      if (sel < 19) return $urandom_range(5, 15);
      return $urandom_range(20, 80);
   endfunction

   // Time stamp: clustered low values force ties, high values test unsigned order.
   function automatic logic [STAMP_W-1:0] pick_stamp();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 15);
         1: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   // One random request beat; drain-heavy segments empty the table.
   task automatic issue_random(input bit drain_heavy);
      int                 roll;
      ipt_op_type         op;
      logic [FRAME_W-1:0] frame;
      roll  = $urandom_range(0, 99);
      frame = FRAME_W'($urandom_range(0, 1) ? $urandom_range(0, 7)
                                            : $urandom_range(0, FRAMES - 1));
      if (drain_heavy)
         op = (roll < 15) ? OP_ALLOC : (roll < 30) ? OP_TOUCH : (roll < 40) ? OP_DIRTY : OP_EVICT;
      else
         op = (roll < 45) ? OP_ALLOC : (roll < 65) ? OP_TOUCH : (roll < 80) ? OP_DIRTY : OP_EVICT;
      issue(op, frame, PID_W'($urandom), PAGE_W'($urandom), pick_stamp(),
            1'($urandom_range(0, 1)));
   endtask

   // Stimulus: reset, directed beats, then random segments.
   initial begin
      bit drain_heavy;
      bit steady;
      start            = 1'b0;
      reset            = 1'b1;
      req_opcode       = OP_ALLOC;
      req_frame_index  = '0;
      req_owner_pid    = '0;
      req_virtual_page = '0;
      req_ref_time     = '0;
      req_dirty_in     = 1'b0;
      drain_heavy      = 1'b0;
      steady           = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty table, then touch and mark dirty of an invalid frame.
      issue(OP_EVICT, 6'd0, '0, '0, '0, 1'b0);
      issue(OP_TOUCH, 6'd5, 16'h1111, 20'h11111, 32'h5, 1'b0);
      issue(OP_DIRTY, 6'd5, '0, '0, '0, 1'b0);
      issue(OP_EVICT, 6'd5, '0, '0, '0, 1'b0);
      // Field extremes and stamps on both sides of the sign bit.
      issue(OP_ALLOC, 6'd0, 16'h0000, 20'h00000, 32'h0000_0000, 1'b0);
      issue(OP_ALLOC, 6'd63, 16'hFFFF, 20'hFFFFF, 32'hFFFF_FFFF, 1'b1);
      issue(OP_ALLOC, 6'd10, 16'hA5A5, 20'h5A5A5, 32'h8000_0000, 1'b0);
      issue(OP_ALLOC, 6'd11, 16'h5A5A, 20'hA5A5A, 32'h7FFF_FFFF, 1'b1);
      issue(OP_ALLOC, 6'd20, 16'h0020, 20'h00020, 32'h0000_0000, 1'b0);
      // Dirty frame 0, which ties frame 20 and wins on its lower number.
      issue(OP_DIRTY, 6'd0, '0, '0, '0, 1'b0);
      issue(OP_EVICT, 6'd0, '0, '0, '0, 1'b0);
      issue(OP_EVICT, 6'd0, '0, '0, '0, 1'b0);
      // Touch moves frame 11 to the newest stamp; a valid frame is replaced.
      issue(OP_TOUCH, 6'd11, '0, '0, 32'hFFFF_FFFF, 1'b0);
      issue(OP_ALLOC, 6'd63, 16'h1234, 20'h56789, 32'h0000_0005, 1'b0);
      issue(OP_EVICT, 6'd0, '0, '0, '0, 1'b0);
      issue(OP_EVICT, 6'd0, '0, '0, '0, 1'b0);
      issue(OP_EVICT, 6'd0, '0, '0, '0, 1'b0);
      issue(OP_EVICT, 6'd0, '0, '0, '0, 1'b0);

      // Random segments each lean toward filling or draining the table.
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 50 == 0) begin
            drain_heavy = ($urandom_range(0, 2) == 0);
            steady      = ($urandom_range(0, 3) == 0);
         end
         // Hold off once until every owed eviction has come back.
         if (n == RANDOM_BEATS / 2) begin
            start <= 1'b0;
            do @(posedge clock); while (tracker.pending_victims.size() != 0);
         end
         issue_random(drain_heavy);
         if (!steady) idle(pick_gap());
      end
      start <= 1'b0;

      // Drain the remaining responses, then allow for a late stray beat.
      while (tracker.pending_victims.size() != 0) @(posedge clock);
      repeat (FRAMES + 10) @(posedge clock);
      if (tracker.error_count == 0 && tracker.pending_victims.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
rtl/ipt_lru_pkg.sv
rtl/ipt_lru_entry_ram.sv
rtl/ipt_lru_min_unit.sv
rtl/inverted_page_table_lru_top.sv
tb/sv/inverted_page_table_lru_top_tb.sv
